>>> design/dmn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmn_pkg - shared types and constants of the distributed mutex node
// Command and message codes, register indexes, the job passed from the
// front end to the message sequencer, and small helper functions.
// ----------------------------------------------------------------------------
package dmn_pkg;

	localparam int NODES_DEFAULT = 8;
	localparam int MAX_NODES     = 8;   // peer masks are one byte

	localparam int CMD_W   = 3;
	localparam int ID_W    = 3;
	localparam int STAMP_W = 32;
	localparam int KIND_W  = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CMD_W-1:0] CMD_LOCAL_REQ  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LOCAL_REL  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOTE_REQ = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REMOTE_REP = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REQ_LOST   = 3'd4;

	localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REPLY   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_GRANT   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_NODE_ID   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PEER_MASK = 1'd1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// One job = one message kind sent to every node set in the mask, in
	// ascending order, all carrying the same stamp. A grant uses bit 0.
	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [MAX_NODES-1:0] mask;
		logic [STAMP_W-1:0]   stamp;
	} job_t;

	function automatic logic [STAMP_W-1:0] sat_inc(input logic [STAMP_W-1:0] v);
		sat_inc = (v == '1) ? v : v + STAMP_W'(1);
	endfunction

	// Nodes 0 .. min(n,8)-1 take part in a request scan.
	function automatic logic [MAX_NODES-1:0] scan_mask(input int n);
		logic [MAX_NODES-1:0] m;
		m = '0;
		for (int i = 0; i < MAX_NODES; i++) begin
			m[i] = (i < n);
		end
		scan_mask = m;
	endfunction

	function automatic logic [ID_W-1:0] popcount3(input logic [MAX_NODES-1:0] m);
		logic [ID_W:0] c;
		c = '0;
		for (int i = 0; i < MAX_NODES; i++) begin
			c = c + (ID_W+1)'(m[i]);
		end
		popcount3 = c[ID_W-1:0];
	endfunction

	function automatic logic [ID_W-1:0] lowest_index(input logic [MAX_NODES-1:0] m);
		logic [ID_W-1:0] idx;
		idx = '0;
		for (int i = MAX_NODES - 1; i >= 0; i--) begin
			if (m[i]) begin
				idx = ID_W'(i);
			end
		end
		lowest_index = idx;
	endfunction

endpackage
`default_nettype wire

>>> design/dmn_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmn_if - valid/ready channels of the distributed mutex node
// Command channel into the node and message channel out of it.
// ----------------------------------------------------------------------------
interface dmn_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [dmn_pkg::CMD_W-1:0]   cmd;
	logic [dmn_pkg::ID_W-1:0]    peer;
	logic [dmn_pkg::STAMP_W-1:0] stamp;

	modport source (output valid, cmd, peer, stamp, input ready);
	modport sink   (input valid, cmd, peer, stamp, output ready);
endinterface

interface dmn_res_if;
	logic                        valid;
	logic                        ready;
	logic [dmn_pkg::KIND_W-1:0]  out_kind;
	logic [dmn_pkg::ID_W-1:0]    out_peer;
	logic [dmn_pkg::STAMP_W-1:0] out_stamp;
	logic                        last;

	modport source (output valid, out_kind, out_peer, out_stamp, last, input ready);
	modport sink   (input valid, out_kind, out_peer, out_stamp, last, output ready);
endinterface
`default_nettype wire

>>> design/dmn_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmn_front - protocol front end
// Takes one command a cycle while the job queue has room, updates the Lamport clock and request state,
// and queues a message job when the command causes any messages.
// ----------------------------------------------------------------------------
module dmn_front #(
	parameter int NODES = dmn_pkg::NODES_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [dmn_pkg::ID_W-1:0]      node_id,
	input  wire logic [dmn_pkg::MAX_NODES-1:0] peer_mask,
	dmn_cmd_if.sink                            cmd_ch,
	output      logic                          push,
	output      dmn_pkg::job_t                 push_job,
	input  wire logic                          full
);

	localparam logic [dmn_pkg::MAX_NODES-1:0] SCAN_MASK = dmn_pkg::scan_mask(NODES);

	logic [dmn_pkg::STAMP_W-1:0]   clock_q, clock_d;
	logic [dmn_pkg::STAMP_W-1:0]   own_stamp_q, own_stamp_d;
	logic                          waiting_q, waiting_d;
	logic [dmn_pkg::ID_W-1:0]      outstanding_q, outstanding_d;
	logic [dmn_pkg::MAX_NODES-1:0] deferred_q, deferred_d;

	logic                          accept;
	logic [dmn_pkg::STAMP_W-1:0]   clock_inc, clock_max, clock_upd;
	logic [dmn_pkg::MAX_NODES-1:0] self_bit, peer_bit, req_mask;
	logic                          prio;

	assign cmd_ch.ready = !full;
	assign accept       = cmd_ch.valid && !full;

	assign clock_inc = dmn_pkg::sat_inc(clock_q);
	assign clock_max = (clock_q > cmd_ch.stamp) ? clock_q : cmd_ch.stamp;
	assign clock_upd = dmn_pkg::sat_inc(clock_max);
	assign self_bit  = dmn_pkg::MAX_NODES'(1) << node_id;
	assign peer_bit  = dmn_pkg::MAX_NODES'(1) << cmd_ch.peer;
	assign req_mask  = peer_mask & SCAN_MASK & ~self_bit;
	// older own stamp wins; a tie goes to the lower node id
	assign prio = (own_stamp_q != cmd_ch.stamp) ? (own_stamp_q < cmd_ch.stamp)
	                                            : (node_id < cmd_ch.peer);

	always_comb begin
		clock_d       = clock_q;
		own_stamp_d   = own_stamp_q;
		waiting_d     = waiting_q;
		outstanding_d = outstanding_q;
		deferred_d    = deferred_q;
		push          = 1'b0;
		push_job      = '0;
		if (accept) begin
			case (cmd_ch.cmd)
				dmn_pkg::CMD_LOCAL_REQ: begin
					if (!waiting_q) begin
						clock_d        = clock_inc;
						own_stamp_d    = clock_inc;
						waiting_d      = 1'b1;
						deferred_d     = '0;
						outstanding_d  = dmn_pkg::popcount3(req_mask);
						push           = 1'b1;
						push_job.stamp = clock_inc;
						if (req_mask == '0) begin
							push_job.kind = dmn_pkg::KIND_GRANT;
							push_job.mask = dmn_pkg::MAX_NODES'(1);
						end else begin
							push_job.kind = dmn_pkg::KIND_REQUEST;
							push_job.mask = req_mask;
						end
					end
				end
				dmn_pkg::CMD_LOCAL_REL: begin
					push           = (deferred_q != '0);
					push_job.kind  = dmn_pkg::KIND_REPLY;
					push_job.mask  = deferred_q;
					push_job.stamp = clock_q;
					waiting_d      = 1'b0;
					outstanding_d  = '0;
					deferred_d     = '0;
					own_stamp_d    = '0;
				end
				dmn_pkg::CMD_REMOTE_REQ: begin
					clock_d = clock_upd;
					if (waiting_q && prio && (cmd_ch.peer != node_id)) begin
						deferred_d = deferred_q | peer_bit;
					end else begin
						push           = 1'b1;
						push_job.kind  = dmn_pkg::KIND_REPLY;
						push_job.mask  = peer_bit;
						push_job.stamp = clock_upd;
					end
				end
				dmn_pkg::CMD_REMOTE_REP, dmn_pkg::CMD_REQ_LOST: begin
					if (cmd_ch.cmd == dmn_pkg::CMD_REMOTE_REP) begin
						clock_d = clock_upd;
					end
					if (outstanding_q != '0) begin
						outstanding_d = outstanding_q - dmn_pkg::ID_W'(1);
						if ((outstanding_q == dmn_pkg::ID_W'(1)) && waiting_q) begin
							push           = 1'b1;
							push_job.kind  = dmn_pkg::KIND_GRANT;
							push_job.mask  = dmn_pkg::MAX_NODES'(1);
							push_job.stamp = own_stamp_q;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q       <= '0;
			own_stamp_q   <= '0;
			waiting_q     <= 1'b0;
			outstanding_q <= '0;
			deferred_q    <= '0;
		end else begin
			clock_q       <= clock_d;
			own_stamp_q   <= own_stamp_d;
			waiting_q     <= waiting_d;
			outstanding_q <= outstanding_d;
			deferred_q    <= deferred_d;
		end
	end

`ifndef SYNTH
	// replies are only counted while a request is open
	a_outstanding_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		(outstanding_q != '0) |-> waiting_q)
		else $error("outstanding replies without an open request");
	// an empty job would make the sequencer send a stray message to node 0
	a_job_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_job.mask != '0))
		else $error("empty job queued");
`endif

endmodule
`default_nettype wire

>>> design/dmn_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmn_queue - job queue between front end and sequencer
// Small first-word-fall-through queue of message jobs.
// ----------------------------------------------------------------------------
module dmn_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire dmn_pkg::job_t push_job,
	output      logic          full,
	input  wire logic          pop,
	output      logic          head_valid,
	output      dmn_pkg::job_t head_job
);

	dmn_pkg::job_t                   entry_q [dmn_pkg::QUEUE_DEPTH];
	logic [dmn_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [dmn_pkg::QUEUE_CNT_W-1:0] count_q;
	logic                            do_push, do_pop;

	function automatic logic [dmn_pkg::QUEUE_PTR_W-1:0] next_ptr(
		input logic [dmn_pkg::QUEUE_PTR_W-1:0] p);
		next_ptr = (p == dmn_pkg::QUEUE_PTR_W'(dmn_pkg::QUEUE_DEPTH - 1))
		         ? '0 : p + dmn_pkg::QUEUE_PTR_W'(1);
	endfunction

	assign full       = (count_q == dmn_pkg::QUEUE_CNT_W'(dmn_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + dmn_pkg::QUEUE_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - dmn_pkg::QUEUE_CNT_W'(1);
			end
		end
	end

`ifndef SYNTH
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job pushed into a full queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dmn_pkg::QUEUE_CNT_W'(dmn_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

>>> design/dmn_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmn_back - message sequencer
// Takes one job from the queue and sends one message a cycle while res_ch is
// not stalled, lowest node first, into a registered output stage.
// ----------------------------------------------------------------------------
module dmn_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire dmn_pkg::job_t head_job,
	output      logic          pop,
	dmn_res_if.source          res_ch
);

	logic                          active_q;
	logic [dmn_pkg::KIND_W-1:0]    kind_q;
	logic [dmn_pkg::MAX_NODES-1:0] rem_q;
	logic [dmn_pkg::STAMP_W-1:0]   stamp_q;

	logic                          out_valid_q;
	logic [dmn_pkg::KIND_W-1:0]    out_kind_q;
	logic [dmn_pkg::ID_W-1:0]      out_peer_q;
	logic [dmn_pkg::STAMP_W-1:0]   out_stamp_q;
	logic                          out_last_q;

	logic                          advance;
	logic [dmn_pkg::MAX_NODES-1:0] low_bit, rem_next;

	assign pop      = !active_q && head_valid;
	assign advance  = !out_valid_q || res_ch.ready;
	assign low_bit  = rem_q & (~rem_q + dmn_pkg::MAX_NODES'(1));
	assign rem_next = rem_q & ~low_bit;

	assign res_ch.valid     = out_valid_q;
	assign res_ch.out_kind  = out_kind_q;
	assign res_ch.out_peer  = out_peer_q;
	assign res_ch.out_stamp = out_stamp_q;
	assign res_ch.last      = out_last_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q  <= head_job.kind;
			stamp_q <= head_job.stamp;
		end
		if (advance && active_q) begin
			out_kind_q  <= kind_q;
			out_peer_q  <= dmn_pkg::lowest_index(rem_q);
			out_stamp_q <= stamp_q;
			out_last_q  <= (rem_next == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
				rem_q    <= head_job.mask;
			end else if (advance && active_q) begin
				rem_q    <= rem_next;
				active_q <= (rem_next != '0);
			end
			if (advance) begin
				out_valid_q <= active_q;
			end
		end
	end

`ifndef SYNTH
	// a live job always has a destination left
	a_active_has_dest: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (rem_q != '0))
		else $error("active job with no destination left");
`endif

endmodule
`default_nettype wire

>>> design/distributed_mutex_node.sv
`default_nettype none
// ----------------------------------------------------------------------------
// distributed_mutex_node - one node of Ricart-Agrawala mutual exclusion
// Lamport-clocked node: front end keeps protocol state, a job queue, and a
// message sequencer that sends requests, replies and grants.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  --------+-----+--------------+------------------------------------------
//  cmd_ch  | in  | valid/ready  | cmd, peer, stamp
//  res_ch  | out | valid/ready  | out_kind, out_peer, out_stamp, last
//  cfg     | in  | cfg_we only  | cfg_index, cfg_data (node_id, peer_mask)
//
//  A command is taken whenever the job queue has room.
//  For a command that sends messages, the sequencer first loads the job,
//  then sends one message per cycle while res_ch is not stalled; it sets the rate.
//  Commands that send nothing never reach the sequencer.
//  A stalled res_ch holds the output register; up to two jobs then wait
//  in the queue before cmd_ch.ready drops.
//  arst_n clears clock, request state, queue and output valid at once.
// ----------------------------------------------------------------------------
module distributed_mutex_node #(
	parameter int NODES = dmn_pkg::NODES_DEFAULT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [dmn_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dmn_pkg::CFG_DATA_W-1:0] cfg_data,
	dmn_cmd_if.sink                             cmd_ch,
	dmn_res_if.source                           res_ch
);

	// configuration registers; the user must write them only while the node is idle, the block does not enforce it
	logic [dmn_pkg::ID_W-1:0]      node_id_q;
	logic [dmn_pkg::MAX_NODES-1:0] peer_mask_q;

	// front end to queue
	logic          push;
	dmn_pkg::job_t push_job;
	logic          full;

	// queue to sequencer
	logic          pop;
	logic          head_valid;
	dmn_pkg::job_t head_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q   <= '0;
			peer_mask_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				dmn_pkg::REG_NODE_ID:   node_id_q   <= cfg_data[dmn_pkg::ID_W-1:0];
				dmn_pkg::REG_PEER_MASK: peer_mask_q <= cfg_data[dmn_pkg::MAX_NODES-1:0];
				default: begin
				end
			endcase
		end
	end

	// classify each command, update clock/waiting/deferred state, build job
	dmn_front #(
		.NODES (NODES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.node_id   (node_id_q),
		.peer_mask (peer_mask_q),
		.cmd_ch    (cmd_ch),
		.push      (push),
		.push_job  (push_job),
		.full      (full)
	);

	// decouples command intake from message output
	dmn_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// walk the job's node mask, one message per cycle while res_ch is not stalled, last on the final one
	dmn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.res_ch     (res_ch)
	);

endmodule
`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench - self-checking bench for distributed_mutex_node
// Drives lock commands over the command channel, mirrors the node's protocol
// state in a scoreboard, and checks every message leaving the node in order.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dmn_pkg::*;

	// Commands 5 to 7 carry no meaning; the node must drop them silently.
	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam int SPARE_CMDS = 3;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_OFF_CYCLES = 300;

	// ------------------------------------------------------------------------
	// Scoreboard: mirrors clock, lock state and registers, and holds the
	// messages still owed by the node, oldest first.
	// ------------------------------------------------------------------------
	class mutex_scoreboard;
		typedef struct {
			logic [KIND_W-1:0]  kind;
			logic [ID_W-1:0]    dest;
			logic [STAMP_W-1:0] stamp;
			logic               last;
		} message_t;

		logic [ID_W-1:0]      node_id;
		logic [MAX_NODES-1:0] peer_mask;
		logic [STAMP_W-1:0]   lclock;
		logic [STAMP_W-1:0]   own_stamp;
		logic                 waiting;
		logic [ID_W-1:0]      outstanding;
		logic [MAX_NODES-1:0] deferred;
		message_t             pending[$];
		int                   errors;

		function new();
			node_id     = '0;
			peer_mask   = '0;
			lclock      = '0;
			own_stamp   = '0;
			waiting     = 1'b0;
			outstanding = '0;
			deferred    = '0;
			errors      = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_NODE_ID) begin
				node_id = data[ID_W-1:0];
			end else begin
				peer_mask = data[MAX_NODES-1:0];
			end
		endfunction

		// Lamport tick, sticking at the top of the range
		function logic [STAMP_W-1:0] bump(logic [STAMP_W-1:0] v);
			return (&v) ? v : v + STAMP_W'(1);
		endfunction

		// one message, not yet marked as the last of its batch
		function message_t make_msg(logic [KIND_W-1:0] kind, logic [ID_W-1:0] dest,
				logic [STAMP_W-1:0] stamp);
			message_t m;
			m.kind  = kind;
			m.dest  = dest;
			m.stamp = stamp;
			m.last  = 1'b0;
			return m;
		endfunction

		// one reply fewer to wait for; true when that completes the lock
		function bit count_down();
			if (outstanding != '0) begin
				outstanding = outstanding - ID_W'(1);
				return (outstanding == '0) && waiting;
			end
			return 1'b0;
		endfunction

		function void note_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] src,
				logic [STAMP_W-1:0] stamp);
			message_t batch[$];
			logic     ahead;
			case (cmd)
				CMD_LOCAL_REQ: begin
					if (!waiting) begin
						lclock    = bump(lclock);
						own_stamp = lclock;
						waiting   = 1'b1;
						deferred  = '0;
						for (int i = 0; i < MAX_NODES; i++) begin
							if (i != node_id && peer_mask[i]) begin
								batch.insert(batch.size(),
										make_msg(KIND_REQUEST, ID_W'(i), own_stamp));
							end
						end
						outstanding = ID_W'(batch.size());
						// nobody to ask: the section is ours straight away
						if (batch.size() == 0) begin
							batch.insert(batch.size(), make_msg(KIND_GRANT, '0, own_stamp));
						end
					end
				end
				CMD_LOCAL_REL: begin
					for (int i = 0; i < MAX_NODES; i++) begin
						if (deferred[i]) begin
							batch.insert(batch.size(), make_msg(KIND_REPLY, ID_W'(i), lclock));
						end
					end
					waiting     = 1'b0;
					outstanding = '0;
					deferred    = '0;
					own_stamp   = '0;
				end
				CMD_REMOTE_REQ: begin
					lclock = bump((lclock > stamp) ? lclock : stamp);
					// older stamp wins; on a tie the lower node id wins
					ahead = (own_stamp != stamp) ? (own_stamp < stamp) : (node_id < src);
					if (waiting && ahead && src != node_id) begin
						deferred[src] = 1'b1;
					end else begin
						batch.insert(batch.size(), make_msg(KIND_REPLY, src, lclock));
					end
				end
				CMD_REMOTE_REP: begin
					lclock = bump((lclock > stamp) ? lclock : stamp);
					if (count_down()) begin
						batch.insert(batch.size(), make_msg(KIND_GRANT, '0, own_stamp));
					end
				end
				CMD_REQ_LOST: begin
					if (count_down()) begin
						batch.insert(batch.size(), make_msg(KIND_GRANT, '0, own_stamp));
					end
				end
				default: begin
				end
			endcase
			if (batch.size() != 0) begin
				batch[batch.size() - 1].last = 1'b1;
			end
			foreach (batch[i]) begin
				pending.insert(pending.size(), batch[i]);
			end
		endfunction

		task report(string what);
			if (errors < 40) begin
				$display("mismatch at %0t: %s", $time, what);
			end
			errors++;
		endtask

		task check_result(logic [KIND_W-1:0] kind, logic [ID_W-1:0] dest,
				logic [STAMP_W-1:0] stamp, logic last);
			message_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected message kind %0d to node %0d", kind, dest));
				return;
			end
			want = pending.pop_front();
			if (kind !== want.kind) begin
				report($sformatf("out_kind %0d, expected %0d", kind, want.kind));
			end
			if (dest !== want.dest) begin
				report($sformatf("out_peer %0d, expected %0d", dest, want.dest));
			end
			if (stamp !== want.stamp) begin
				report($sformatf("out_stamp %0h, expected %0h", stamp, want.stamp));
			end
			if (last !== want.last) begin
				report($sformatf("last %0b, expected %0b", last, want.last));
			end
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dmn_cmd_if cmd_ch ();
	dmn_res_if res_ch ();

	distributed_mutex_node #(
		.NODES(8)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd_ch   (cmd_ch),
		.res_ch   (res_ch)
	);

	mutex_scoreboard sb;
	bit calm;          // set for a stretch with no idling on either side
	int hold_off = 0;  // long receiver stall, counted down by the sink
	int sent = 0;      // requests taken by the node that mean something to it

	initial begin
		forever #5 clk = ~clk;
	end

	// Both channels are sampled at the rising edge; inputs change on the
	// falling edge, so the handshake values are settled by then.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				sb.note_request(cmd_ch.cmd, cmd_ch.peer, cmd_ch.stamp);
			end
			if (res_ch.valid && res_ch.ready) begin
				sb.check_result(res_ch.out_kind, res_ch.out_peer, res_ch.out_stamp,
						res_ch.last);
			end
		end
	end

	// mostly back to back, now and then a short pause, rarely a long one
	function automatic int pick_gap();
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Message sink: random stalls, plus one long hold-off on demand so that
	// the job queue fills and the node pushes back on the command channel.
	initial begin
		int gap;
		gap = 0;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				res_ch.ready = 1'b0;
				hold_off--;
			end else if (gap > 0) begin
				res_ch.ready = 1'b0;
				gap--;
			end else begin
				res_ch.ready = 1'b1;
				gap = pick_gap();
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	// with valid still high, so a following request can go back to back.
	task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] src,
			logic [STAMP_W-1:0] stamp);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid = 1'b1;
		cmd_ch.cmd   = cmd;
		cmd_ch.peer  = src;
		cmd_ch.stamp = stamp;
		do begin
			@(posedge clk);
		end while (!cmd_ch.ready);
		@(negedge clk);
		if (cmd <= CMD_REQ_LOST) begin
			sent++;
		end
	endtask

	// drop valid, drain every owed message, then let the front end settle
	task automatic idle();
		cmd_ch.valid = 1'b0;
		while (sb.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// upper bits of the node id write are junk and must be ignored
	task automatic set_config(logic [ID_W-1:0] id, logic [MAX_NODES-1:0] mask);
		idle();
		write_reg(REG_NODE_ID, {(CFG_DATA_W - ID_W)'($urandom), id});
		write_reg(REG_PEER_MASK, mask);
	endtask

	// stamp within a couple of ticks of base, so ties and near misses happen
	function automatic logic [STAMP_W-1:0] around(logic [STAMP_W-1:0] base);
		logic [STAMP_W-1:0] d;
		d = STAMP_W'($urandom_range(0, 4));
		return (base < 2) ? base + d : base - STAMP_W'(2) + d;
	endfunction

	function automatic logic [ID_W-1:0] any_node();
		return ID_W'($urandom_range(0, MAX_NODES - 1));
	endfunction

	// anything at all, spare commands included
	task automatic noise_cmd(bit full_range);
		logic [STAMP_W-1:0] stamp;
		stamp = full_range ? STAMP_W'($urandom) : around(sb.lclock);
		send_cmd(CMD_W'($urandom_range(0, 7)), any_node(), stamp);
	endtask

	// One lock cycle: ask, collect replies (some lost), field competing lock
	// requests from other nodes along the way, then usually release.
	task automatic lock_cycle();
		int guard;
		int r;
		guard = 0;
		send_cmd(CMD_LOCAL_REQ, any_node(), STAMP_W'($urandom));
		while (sb.outstanding != '0 && guard < 24) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				send_cmd(CMD_REMOTE_REP, any_node(), around(sb.lclock));
			end else if (r < 65) begin
				send_cmd(CMD_REQ_LOST, any_node(), STAMP_W'($urandom));
			end else if (r < 92) begin
				send_cmd(CMD_REMOTE_REQ, any_node(), around(sb.own_stamp));
			end else begin
				noise_cmd(1'b0);
			end
			guard++;
		end
		// contenders arriving while we hold the section
		repeat ($urandom_range(0, 2)) begin
			send_cmd(CMD_REMOTE_REQ, any_node(), around(sb.own_stamp));
		end
		if ($urandom_range(0, 9) != 0) begin
			send_cmd(CMD_LOCAL_REL, any_node(), STAMP_W'($urandom));
		end
	endtask

	task automatic run_phase(logic [ID_W-1:0] id, logic [MAX_NODES-1:0] mask, int quota);
		int start;
		set_config(id, mask);
		start = sent;
		while (sent - start < quota) begin
			if ($urandom_range(0, 99) < 80) begin
				lock_cycle();
			end else begin
				noise_cmd(1'b0);
			end
		end
	endtask

	initial begin
		logic [ID_W-1:0] id;
		sb = new();
		calm         = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_NODE_ID;
		cfg_data     = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.cmd   = CMD_LOCAL_REQ;
		cmd_ch.peer  = '0;
		cmd_ch.stamp = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Node 0, nobody connected (reset values of both registers)
		send_cmd(CMD_LOCAL_REQ, 3'd7, '1);   // immediate grant
		send_cmd(CMD_LOCAL_REQ, 3'd0, '0);   // already waiting: dropped
		send_cmd(CMD_REMOTE_REQ, 3'd3, '0);  // older stamp from peer: answered
		send_cmd(CMD_REMOTE_REQ, 3'd0, 32'd2);  // from ourselves: never deferred
		send_cmd(CMD_LOCAL_REL, 3'd0, '1);   // nothing deferred: silent
		send_cmd(CMD_REMOTE_REP, 3'd4, 32'd5);  // nothing outstanding: clock only
		send_cmd(CMD_REQ_LOST, 3'd7, '0);    // nothing outstanding: no effect
		for (int k = 0; k < SPARE_CMDS; k++) begin
			send_cmd(CMD_W'(CMD_SPARE_FIRST + k), ID_W'(k), '1);
		end

		// Node 3 with everyone connected: full scan, tie-breaks both ways
		set_config(3'd3, 8'hFF);
		send_cmd(CMD_LOCAL_REQ, 3'd0, '0);
		send_cmd(CMD_REMOTE_REQ, 3'd5, sb.own_stamp);   // tie, we are lower: defer
		send_cmd(CMD_REMOTE_REQ, 3'd1, sb.own_stamp);   // tie, they are lower: reply
		send_cmd(CMD_REMOTE_REQ, 3'd6, sb.own_stamp + 1);  // younger: defer
		send_cmd(CMD_REMOTE_REQ, 3'd0, sb.own_stamp - 1);  // older: reply
		send_cmd(CMD_REMOTE_REQ, 3'd3, sb.own_stamp + 1);  // own id: reply
		for (int k = 0; k < 6; k++) begin
			send_cmd(CMD_REMOTE_REP, ID_W'(k), '0);
		end
		send_cmd(CMD_REQ_LOST, 3'd7, '1);    // last one lost: grant
		send_cmd(CMD_REMOTE_REP, 3'd2, '0);  // spurious reply
		send_cmd(CMD_LOCAL_REL, 3'd0, '0);   // deferred replies to 5 and 6

		// Highest id, all connected; the sink holds off for a long stretch
		// while lock traffic keeps coming, so the node must push back.
		set_config(3'd7, 8'hFF);
		hold_off = HOLD_OFF_CYCLES;
		run_phase(3'd7, 8'hFF, 70);

		// lowest id, no idling anywhere
		calm = 1'b1;
		run_phase(3'd0, 8'hFF, 70);
		calm = 1'b0;

		run_phase(any_node(), MAX_NODES'($urandom), 70);

		// connected only to ourselves: every lock is granted at once
		id = any_node();
		run_phase(id, MAX_NODES'(1) << id, 70);

		run_phase(any_node(), MAX_NODES'($urandom_range(1, 254)), 70);

		// Wide stamps last, since the clock never comes back down once it
		// has jumped; end on a saturated clock with tied stamps.
		id = any_node();
		set_config(id, 8'hFF);
		repeat (30) noise_cmd(1'b1);
		send_cmd(CMD_LOCAL_REL, 3'd0, '0);
		send_cmd(CMD_REMOTE_REQ, 3'd1, '1);   // clock sticks at the top
		send_cmd(CMD_LOCAL_REQ, 3'd0, '0);    // own stamp at the top too
		send_cmd(CMD_REMOTE_REQ, 3'd0, '1);
		send_cmd(CMD_REMOTE_REQ, 3'd7, '1);
		send_cmd(CMD_REMOTE_REP, 3'd2, '1);
		repeat (2) lock_cycle();
		send_cmd(CMD_LOCAL_REL, 3'd0, '1);

		idle();
		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// generous bound: several times the slowest legal run
	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
